### src/p2rdf_pkg.sv
package p2rdf_pkg;

    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    localparam logic [2:0] CFG_RADIX_ADDR = 3'd0;

    typedef enum logic [1:0] {
        MODE_BIN,
        MODE_OCT,
        MODE_HEX
    } t_mode;

    typedef struct packed {
        logic [1:0] radix_select;
    } t_cfg;

endpackage

### src/pow2_radix_digit_formatter.sv
// Emits the digits of a VALUE_BITS-wide integer in binary, octal or hex (radix_select at
// address 0; code three reads as hex), most significant first, one transfer per digit, with
// minus, group-space and last marks. The radix is sampled when the number is taken. An item
// is loaded, then the shared digit shifter makes one pass per position of the full digit
// count of the width (VALUE_BITS for binary, ceil(VALUE_BITS/3) octal, ceil(VALUE_BITS/4)
// hex), leading zeros skipped and each remaining digit sent, a digit waiting while the
// output is stalled. Input ready is high only between numbers; the final digit may
// still wait at the output while the next number is taken.
module pow2_radix_digit_formatter #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_number,
    input  logic        i_sign_en,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_digit,
    output logic        o_minus_before,
    output logic        o_space_before,
    output logic        o_last
);
    import p2rdf_pkg::*;

    localparam int REM_W    = $clog2(VALUE_BITS + 1);
    localparam int MAXD_BIN = VALUE_BITS;
    localparam int MAXD_OCT = (VALUE_BITS + 2) / 3;
    localparam int MAXD_HEX = (VALUE_BITS + 3) / 4;
    localparam logic [1:0] OCT_MOD3 = 2'(MAXD_OCT % 3);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_neg;
    logic                  r_lead;
    logic [REM_W-1:0]      r_rem;
    logic [1:0]            r_mod3;
    t_mode                 r_mode;

    t_cfg                  w_cfg;
    t_mode                 w_mode;
    logic [VALUE_BITS-1:0] w_v;
    logic                  w_sneg;
    logic [3:0]            w_digit;
    logic                  w_skip;
    logic                  w_slot;
    logic                  w_emit;
    logic                  w_group;
    logic [1:0]            n_mod3;

    p2rdf_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    p2rdf_digit_unit #(
        .VALUE_BITS (VALUE_BITS),
        .REM_W      (REM_W)
    ) u_digit (
        .i_val   (r_val),
        .i_rem   (r_rem),
        .i_mode  (r_mode),
        .o_digit (w_digit)
    );

    always_comb begin
        case (w_cfg.radix_select)
            RADIX_BIN: w_mode = MODE_BIN;
            RADIX_OCT: w_mode = MODE_OCT;
            default:   w_mode = MODE_HEX;
        endcase
    end

    assign w_v     = i_number[VALUE_BITS-1:0];
    assign w_sneg  = i_sign_en & w_v[VALUE_BITS-1];
    assign o_ready = (r_state == S_IDLE);
    assign w_skip  = r_lead && (w_digit == 4'd0) && (r_rem != REM_W'(1));
    assign w_slot  = !o_valid || i_ready;
    assign w_emit  = (r_state == S_RUN) && !w_skip && w_slot;
    assign w_group = (r_mode == MODE_OCT) ? (r_mod3 == 2'd0) : (r_rem[1:0] == 2'b00);
    assign n_mod3  = (r_mod3 == 2'd0) ? 2'd2 : r_mod3 - 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_valid <= 1'b0;
            r_lead  <= 1'b0;
        end else begin
            if (w_emit) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_RUN;
                        r_lead  <= 1'b1;
                        r_neg   <= w_sneg;
                        r_val   <= w_sneg ? (~w_v + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : w_v;
                        r_mode  <= w_mode;
                        r_mod3  <= OCT_MOD3;
                        case (w_mode)
                            MODE_BIN: r_rem <= REM_W'(MAXD_BIN);
                            MODE_OCT: r_rem <= REM_W'(MAXD_OCT);
                            default:  r_rem <= REM_W'(MAXD_HEX);
                        endcase
                    end
                end
                S_RUN: begin
                    if (w_skip) begin
                        r_rem  <= r_rem - REM_W'(1);
                        r_mod3 <= n_mod3;
                    end else if (w_slot) begin
                        o_digit        <= w_digit;
                        o_minus_before <= r_lead & r_neg;
                        o_space_before <= !r_lead && w_group;
                        o_last         <= (r_rem == REM_W'(1));
                        r_lead         <= 1'b0;
                        r_rem          <= r_rem - REM_W'(1);
                        r_mod3         <= n_mod3;
                        if (r_rem == REM_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_load_starts_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_RUN) && r_lead)
        else $error("accepted number did not start a leading-zero scan");

    a_rem_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_rem != '0))
        else $error("digit counter ran out while running");

    a_mod3_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_mode == MODE_OCT) |-> (r_mod3 == 2'(r_rem % 3)))
        else $error("octal group phase lost track of digit counter");

    a_minus_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_minus_before) |-> !o_space_before)
        else $error("minus and space marked on same digit");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !w_skip && w_slot && r_rem == REM_W'(1))
            |=> (r_state == S_IDLE) && o_valid && o_last)
        else $error("final digit did not end the number");

endmodule

### src/p2rdf_apb_regs.sv
module p2rdf_apb_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output p2rdf_pkg::t_cfg   o_cfg
);
    import p2rdf_pkg::*;

    logic [1:0] r_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_HEX;
        end else if (psel && penable && pwrite && (paddr == CFG_RADIX_ADDR)) begin
            r_radix <= pwdata[1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr == CFG_RADIX_ADDR) begin
            prdata = {30'd0, r_radix};
        end
    end

    assign pready = 1'b1;
    assign o_cfg.radix_select = r_radix;

endmodule

### src/p2rdf_digit_unit.sv
module p2rdf_digit_unit #(
    parameter int VALUE_BITS = 64,
    parameter int REM_W      = 7
) (
    input  logic [VALUE_BITS-1:0] i_val,
    input  logic [REM_W-1:0]      i_rem,
    input  p2rdf_pkg::t_mode      i_mode,
    output logic [3:0]            o_digit
);
    import p2rdf_pkg::*;

    logic [REM_W-1:0]      w_dec;
    logic [REM_W+1:0]      w_shamt;
    logic [VALUE_BITS-1:0] w_shifted;

    assign w_dec = i_rem - {{(REM_W-1){1'b0}}, 1'b1};

    always_comb begin
        case (i_mode)
            MODE_BIN: w_shamt = {2'b00, w_dec};
            MODE_OCT: w_shamt = {1'b0, w_dec, 1'b0} + {2'b00, w_dec};
            default:  w_shamt = {w_dec, 2'b00};
        endcase
    end

    assign w_shifted = i_val >> w_shamt;

    always_comb begin
        case (i_mode)
            MODE_BIN: o_digit = {3'b000, w_shifted[0]};
            MODE_OCT: o_digit = {1'b0, w_shifted[2:0]};
            default:  o_digit = w_shifted[3:0];
        endcase
    end

endmodule

### tb/sv/pow2_radix_digit_formatter_chk.sv
`timescale 1ns / 1ps
module pow2_radix_digit_formatter_chk #(
    parameter int VALUE_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [63:0] i_number,
    input  logic        i_sign_en,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [3:0]  o_digit,
    input  logic        o_minus_before,
    input  logic        o_space_before,
    input  logic        o_last,
    output int          o_fail_count,
    output int          o_pending
);
    import p2rdf_pkg::*;

    typedef struct packed {
        logic [3:0] digit;
        logic       minus_before;
        logic       space_before;
        logic       last;
    } t_digit_mark;

    t_digit_mark digits_due[$];
    logic [1:0]  radix_sel = RADIX_HEX;
    int          errs = 0;

    function automatic void queue_digits(input logic [63:0] number, input logic sign_en);
        logic [63:0] vmask;
        logic [63:0] mag;
        logic        neg;
        int unsigned nbits;
        int unsigned group;
        int unsigned n;
        int unsigned rem;
        int unsigned k;
        t_digit_mark d;
        vmask = {64{1'b1}} >> (64 - VALUE_BITS);
        mag   = number & vmask;
        neg   = sign_en && mag[VALUE_BITS-1];
        if (neg) begin
            mag = (~mag + 64'd1) & vmask;
        end
        case (radix_sel)
            RADIX_BIN: begin
                nbits = 1;
                group = 4;
            end
            RADIX_OCT: begin
                nbits = 3;
                group = 3;
            end
            default: begin
                nbits = 4;
                group = 4;
            end
        endcase
        n = 1;
        while (n * nbits < 64 && (mag >> (n * nbits)) != 64'd0) begin
            n++;
        end
        for (k = 0; k < n; k++) begin
            rem            = n - k;
            d.digit        = 4'((mag >> ((rem - 1) * nbits)) & ((64'd1 << nbits) - 64'd1));
            d.minus_before = (k == 0) && neg;
            d.space_before = (k != 0) && (rem % group == 0);
            d.last         = (rem == 1);
            digits_due.push_back(d);
        end
    endfunction

    always @(posedge i_clk) begin
        t_digit_mark got;
        t_digit_mark want;
        if (!i_rst_n) begin
            radix_sel = RADIX_HEX;
            digits_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == CFG_RADIX_ADDR) begin
                        radix_sel = pwdata[1:0];
                    end
                end else if (paddr == CFG_RADIX_ADDR && prdata != {30'd0, radix_sel}) begin
                    errs++;
                    $display("%0t: radix readback expected %h got %h",
                             $time, {30'd0, radix_sel}, prdata);
                end
            end
            if (o_valid && i_ready) begin
                got = '{digit: o_digit, minus_before: o_minus_before,
                        space_before: o_space_before, last: o_last};
                if (digits_due.size() == 0) begin
                    errs++;
                    $display("%0t: digit expected none got digit=%h minus=%b space=%b last=%b",
                             $time, got.digit, got.minus_before, got.space_before, got.last);
                end else begin
                    want = digits_due.pop_front();
                    if (got != want) begin
                        errs++;
                        $display({"%0t: digit expected digit=%h minus=%b space=%b last=%b",
                                  " got digit=%h minus=%b space=%b last=%b"},
                                 $time, want.digit, want.minus_before, want.space_before,
                                 want.last, got.digit, got.minus_before, got.space_before,
                                 got.last);
                    end
                end
            end
            if (i_valid && o_ready) begin
                queue_digits(i_number, i_sign_en);
            end
        end
        o_pending    <= digits_due.size();
        o_fail_count <= errs;
    end

endmodule

### tb/sv/tb_pow2_radix_digit_formatter.sv
`timescale 1ns / 1ps
module tb_pow2_radix_digit_formatter;
    import p2rdf_pkg::*;

    localparam int         VALUE_BITS        = 64;
    localparam int         STALL_LIMIT       = 5000;
    localparam int         ITEMS_PER_SETTING = 30;
    localparam int         SETTLE_CYCLES     = 70;
    localparam logic [1:0] RADIX_SPARE_HEX   = 2'd3;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = CFG_RADIX_ADDR;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid     = 1'b0;
    logic        o_ready;
    logic [63:0] i_number    = '0;
    logic        i_sign_en   = 1'b0;
    logic        o_valid;
    logic        i_ready     = 1'b0;
    logic [3:0]  o_digit;
    logic        o_minus_before;
    logic        o_space_before;
    logic        o_last;
    int          fail_count;
    int          digits_pending;
    int          tx_idle_pct = 38;
    int          rx_idle_pct = 52;
    int          quiet_cycles = 0;

    logic [1:0]  radix_order [4] = '{RADIX_HEX, RADIX_BIN, RADIX_OCT, RADIX_SPARE_HEX};
    logic [63:0] directed_num[6] = '{64'd0, {64{1'b1}}, {64{1'b1}}, 64'h8000_0000_0000_0000,
                                     64'hFFFF_FFFF_FFFF_F000, 64'h0123_4567_89AB_CDEF};
    logic        directed_sgn[6] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};

    pow2_radix_digit_formatter #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_sign_en      (i_sign_en),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit        (o_digit),
        .o_minus_before (o_minus_before),
        .o_space_before (o_space_before),
        .o_last         (o_last)
    );

    pow2_radix_digit_formatter_chk #(
        .VALUE_BITS(VALUE_BITS)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_sign_en      (i_sign_en),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digit        (o_digit),
        .o_minus_before (o_minus_before),
        .o_space_before (o_space_before),
        .o_last         (o_last),
        .o_fail_count   (fail_count),
        .o_pending      (digits_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_number(input logic [63:0] number, input logic sign_en);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_number  <= number;
        i_sign_en <= sign_en;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // write the radix, then read it back
    task automatic set_radix(input logic [1:0] radix);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_RADIX_ADDR;
        pwdata  <= {30'd0, radix};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_digits();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (digits_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_number();
        logic [63:0] v;
        int          len;
        v   = {$urandom, $urandom};
        len = $urandom_range(1, 64);
        v   = v >> (64 - len);
        case ($urandom_range(0, 3))
            0: v = ~v;
            1: v = -v;
            2: v = {$urandom, $urandom};
            default: ;
        endcase
        return v;
    endfunction

    initial begin
        int ph;
        int r;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset radix first, then every other setting
        for (r = 0; r < 4; r++) begin
            if (r != 0) begin
                set_radix(radix_order[r]);
            end
            for (k = 0; k < 6; k++) begin
                send_number(directed_num[k], directed_sgn[k]);
            end
            drain_digits();
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 38;
                    rx_idle_pct = 52;
                end
                1: begin
                    tx_idle_pct = 52;
                    rx_idle_pct = 38;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (r = 0; r < 4; r++) begin
                set_radix(radix_order[(r + ph + 1) % 4]);
                for (k = 0; k < ITEMS_PER_SETTING; k++) begin
                    send_number(random_number(), 1'($urandom_range(0, 1)));
                end
                drain_digits();
            end
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
